// ----- src/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants, register indexes and types of the stepped cross-fade.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Default geometry; the top level hands these down as parameters.
  localparam int DEF_MAX_STAGES   = 256;
  localparam int DEF_CHANNEL_BITS = 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_STAGE_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STAGE_DELAY_MS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_ENABLE    = 2'd2;

  localparam int STAGE_COUNT_W = 9;
  localparam int MS_W          = 16;

  localparam logic [STAGE_COUNT_W-1:0] RST_STAGE_COUNT    = 9'd2;
  localparam logic [MS_W-1:0]          RST_STAGE_DELAY_MS = 16'd100;
  localparam logic                     RST_LOOP_ENABLE    = 1'b0;

  // Item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Channel lanes.
  localparam int LANES = 4;

  // Entries held between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [STAGE_COUNT_W-1:0] stage_count;
    logic [MS_W-1:0]          stage_delay_ms;
    logic                     loop_enable;
  } cfg_t;

  // Queue entry at the default geometry; the top level builds the same
  // layout from its own parameters.
  typedef struct packed {
    logic                                     kind;
    logic [$clog2(DEF_MAX_STAGES)-1:0]        stage;
    logic [$clog2(DEF_MAX_STAGES)-1:0]        k;
    logic [$clog2(DEF_MAX_STAGES)-1:0]        top;
    logic                                     redraw;
    logic [LANES-1:0][DEF_CHANNEL_BITS-1:0]   src;
    logic [LANES-1:0][DEF_CHANNEL_BITS-1:0]   dst;
  } entry_def_t;

endpackage

// ----- src/spc_item_if.sv -----
// ----------------------------------------------------------------------------
// spc_item_if
// Input channel: tick or pixel pair, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spc_item_if #(
  parameter int CHANNEL_BITS = spc_pkg::DEF_CHANNEL_BITS
);
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [spc_pkg::MS_W-1:0] elapsed_ms;
  logic                    enable;
  logic [CHANNEL_BITS-1:0] start_red;
  logic [CHANNEL_BITS-1:0] start_green;
  logic [CHANNEL_BITS-1:0] start_blue;
  logic [CHANNEL_BITS-1:0] start_alpha;
  logic [CHANNEL_BITS-1:0] end_red;
  logic [CHANNEL_BITS-1:0] end_green;
  logic [CHANNEL_BITS-1:0] end_blue;
  logic [CHANNEL_BITS-1:0] end_alpha;

  modport source (
    output valid, kind, elapsed_ms, enable,
           start_red, start_green, start_blue, start_alpha,
           end_red, end_green, end_blue, end_alpha,
    input  ready
  );

  modport sink (
    input  valid, kind, elapsed_ms, enable,
           start_red, start_green, start_blue, start_alpha,
           end_red, end_green, end_blue, end_alpha,
    output ready
  );
endinterface

// ----- src/spc_result_if.sv -----
// ----------------------------------------------------------------------------
// spc_result_if
// Output channel: blended pixel or tick status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spc_result_if #(
  parameter int CHANNEL_BITS = spc_pkg::DEF_CHANNEL_BITS,
  parameter int STAGE_BITS   = $clog2(spc_pkg::DEF_MAX_STAGES)
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;
  logic [CHANNEL_BITS-1:0] out_alpha;
  logic [STAGE_BITS-1:0]   current_stage;
  logic                    redraw;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, current_stage, redraw,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, current_stage, redraw,
    output ready
  );
endinterface

// ----- src/spc_front.sv -----
// ----------------------------------------------------------------------------
// spc_front
// Accept items, run the stage sequencer on ticks, tag each item with the
// stage data it needs and push it into the queue.
// ----------------------------------------------------------------------------
module spc_front #(
  parameter int  MAX_STAGES   = spc_pkg::DEF_MAX_STAGES,
  parameter int  CHANNEL_BITS = spc_pkg::DEF_CHANNEL_BITS,
  parameter type entry_t      = spc_pkg::entry_def_t
) (
  input  logic          clk,
  input  logic          rst,
  input  spc_pkg::cfg_t cfg,
  spc_item_if.sink      item,
  output entry_t        push_data,
  output logic          push_valid,
  input  logic          push_ready
);

  localparam int SW = $clog2(MAX_STAGES);

  logic [SW-1:0]            stage;
  logic [SW-1:0]            stage_next;
  logic                     going_down;
  logic                     going_down_next;
  logic [spc_pkg::MS_W-1:0] countdown;
  logic [spc_pkg::MS_W-1:0] countdown_next;
  logic                     first_pending;
  logic                     first_pending_next;
  logic                     redraw_c;
  logic [SW-1:0]            top;
  logic [SW-1:0]            stage_cl;
  logic                     accept;

  assign accept     = item.valid && push_ready;
  assign item.ready = push_ready;
  assign push_valid = item.valid;

  // Last stage index: stage count limited to [2, MAX_STAGES], minus one.
  always_comb begin
    if (cfg.stage_count < spc_pkg::STAGE_COUNT_W'(2)) begin
      top = SW'(1);
    end else if (int'(cfg.stage_count) > MAX_STAGES) begin
      top = SW'(MAX_STAGES - 1);
    end else begin
      top = SW'(cfg.stage_count - spc_pkg::STAGE_COUNT_W'(1));
    end
  end

  assign stage_cl = (stage > top) ? top : stage;

  // Tick sequencer.
  always_comb begin
    stage_next         = stage;
    going_down_next    = going_down;
    countdown_next     = countdown;
    first_pending_next = first_pending;
    redraw_c           = 1'b0;
    if (item.enable) begin
      priority if (first_pending) begin
        first_pending_next = 1'b0;
        redraw_c           = 1'b1;
      end else if (item.elapsed_ms < countdown) begin
        countdown_next = countdown - item.elapsed_ms;
      end else begin
        countdown_next = cfg.stage_delay_ms;
        stage_next     = stage_cl;
        if (!going_down) begin
          if (stage_cl < top) begin
            stage_next = stage_cl + SW'(1);
            redraw_c   = 1'b1;
          end else if (cfg.loop_enable) begin
            going_down_next = 1'b1;
            redraw_c        = 1'b1;
          end
        end else begin
          if (stage_cl != '0) begin
            stage_next = stage_cl - SW'(1);
            redraw_c   = 1'b1;
          end else if (cfg.loop_enable) begin
            going_down_next = 1'b0;
            redraw_c        = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= '0;
      going_down    <= 1'b0;
      countdown     <= spc_pkg::RST_STAGE_DELAY_MS;
      first_pending <= 1'b1;
    end else if (accept && item.kind == spc_pkg::KIND_TICK) begin
      stage         <= stage_next;
      going_down    <= going_down_next;
      countdown     <= countdown_next;
      first_pending <= first_pending_next;
    end
  end

  always_comb begin
    push_data.kind   = item.kind;
    push_data.stage  = (item.kind == spc_pkg::KIND_PIXEL) ? stage : stage_next;
    push_data.k      = stage_cl;
    push_data.top    = top;
    push_data.redraw = (item.kind == spc_pkg::KIND_PIXEL) ? 1'b0 : redraw_c;
    push_data.src[0] = item.start_red;
    push_data.src[1] = item.start_green;
    push_data.src[2] = item.start_blue;
    push_data.src[3] = item.start_alpha;
    push_data.dst[0] = item.end_red;
    push_data.dst[1] = item.end_green;
    push_data.dst[2] = item.end_blue;
    push_data.dst[3] = item.end_alpha;
  end

  // The first redraw is only ever consumed by an accepted, enabled tick.
  a_first_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    $fell(first_pending) |->
      $past(accept && item.kind == spc_pkg::KIND_TICK && item.enable))
    else $error("first_pending cleared without an enabled tick");

endmodule

// ----- src/spc_queue.sv -----
// ----------------------------------------------------------------------------
// spc_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module spc_queue #(
  parameter type entry_t = spc_pkg::entry_def_t
) (
  input  logic   clk,
  input  logic   rst,
  input  entry_t push_data,
  input  logic   push_valid,
  output logic   push_ready,
  output entry_t pop_data,
  output logic   pop_valid,
  input  logic   pop_ready
);

  localparam int PW = $clog2(spc_pkg::QUEUE_DEPTH);

  entry_t      mem [spc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = (count != (PW+1)'(spc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(spc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(spc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(spc_pkg::QUEUE_DEPTH))
    else $error("queue occupancy beyond its depth");

endmodule

// ----- src/spc_back.sv -----
// ----------------------------------------------------------------------------
// spc_back
// Blend pixel entries and pass tick entries through: one multiply per lane,
// then a restoring divide by the last stage index, one quotient bit per cycle,
// four lanes side by side. Hold each result in an output register until taken.
// ----------------------------------------------------------------------------
module spc_back #(
  parameter int  MAX_STAGES   = spc_pkg::DEF_MAX_STAGES,
  parameter int  CHANNEL_BITS = spc_pkg::DEF_CHANNEL_BITS,
  parameter type entry_t      = spc_pkg::entry_def_t
) (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     pop_data,
  input  logic       pop_valid,
  output logic       pop_ready,
  spc_result_if.source result
);

  localparam int SW = $clog2(MAX_STAGES);
  localparam int CB = CHANNEL_BITS;
  localparam int PB = CB + SW;
  localparam int CW = $clog2(CB);
  localparam int L  = spc_pkg::LANES;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]              state;
  entry_t                  cur;
  logic [CW-1:0]           cnt;
  logic [L-1:0][CB-1:0]    diff;
  logic [L-1:0]            neg;
  logic [L-1:0][SW:0]      rem;
  logic [L-1:0][CB-1:0]    low;
  logic [L-1:0][CB-1:0]    quo;
  logic [L-1:0][PB-1:0]    prod;
  logic [L-1:0][SW:0]      trial;
  logic [L-1:0]            ge;
  logic [L-1:0][CB-1:0]    blend;
  logic                    out_valid;
  logic                    out_free;
  logic [L-1:0][CB-1:0]    out_ch;
  logic [SW-1:0]           out_stage;
  logic                    out_redraw;

  assign pop_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || result.ready;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      prod[i]  = PB'(diff[i]) * PB'(cur.k);
      trial[i] = {rem[i][SW-1:0], low[i][CB-1]};
      ge[i]    = (trial[i] >= {1'b0, cur.top});
      blend[i] = neg[i] ? cur.src[i] - quo[i] : cur.src[i] + quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= (pop_data.kind == spc_pkg::KIND_PIXEL) ? ST_MUL : ST_DONE;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          cur <= pop_data;
          for (int i = 0; i < L; i++) begin
            neg[i]  <= (pop_data.dst[i] < pop_data.src[i]);
            diff[i] <= (pop_data.dst[i] < pop_data.src[i]) ?
                       pop_data.src[i] - pop_data.dst[i] :
                       pop_data.dst[i] - pop_data.src[i];
          end
        end
      end
      ST_MUL: begin
        for (int i = 0; i < L; i++) begin
          rem[i] <= {1'b0, prod[i][PB-1:CB]};
          low[i] <= prod[i][CB-1:0];
          quo[i] <= '0;
        end
        cnt <= CW'(CB - 1);
      end
      ST_DIV: begin
        for (int i = 0; i < L; i++) begin
          rem[i] <= ge[i] ? trial[i] - {1'b0, cur.top} : trial[i];
          low[i] <= {low[i][CB-2:0], 1'b0};
          quo[i] <= {quo[i][CB-2:0], ge[i]};
        end
        cnt <= cnt - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      for (int i = 0; i < L; i++) begin
        out_ch[i] <= (cur.kind == spc_pkg::KIND_PIXEL) ? blend[i] : '0;
      end
      out_stage  <= cur.stage;
      out_redraw <= cur.redraw;
    end
  end

  assign result.valid         = out_valid;
  assign result.out_red       = out_ch[0];
  assign result.out_green     = out_ch[1];
  assign result.out_blue      = out_ch[2];
  assign result.out_alpha     = out_ch[3];
  assign result.current_stage = out_stage;
  assign result.redraw        = out_redraw;

  // The partial remainder stays below the divisor in every lane.
  a_rem_below_top: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |->
      rem[0] < {1'b0, cur.top} && rem[1] < {1'b0, cur.top} &&
      rem[2] < {1'b0, cur.top} && rem[3] < {1'b0, cur.top})
    else $error("divider remainder out of range");

  // A blend never moves past the end pixel.
  a_quo_within_span: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && cur.kind == spc_pkg::KIND_PIXEL |->
      quo[0] <= diff[0] && quo[1] <= diff[1] &&
      quo[2] <= diff[2] && quo[3] <= diff[3])
    else $error("blend step exceeds the channel span");

endmodule

// ----- src/stepped_pingpong_crossfade.sv -----
// ----------------------------------------------------------------------------
// stepped_pingpong_crossfade
// Stepped cross-fade of a start image into an end image, with ping-pong
// looping, driven by tick items and applied to pixel-pair items.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result beat, in order. A tick beat
// (kind 0) runs the stage sequencer: the first enabled tick requests a redraw
// at the current stage, later enabled ticks count down stage_delay_ms and
// step the stage on expiry, reversing at either end when loop_enable is set
// and holding there otherwise; its result carries zero channels, the stage
// in force afterwards and the redraw flag. A pixel beat (kind 1) blends each
// of red, green, blue and alpha as start + trunc((end - start) * k / (S - 1)),
// where S is stage_count limited to [2, MAX_STAGES] and k the stage limited
// to S - 1; the result always lies between start and end. In the back end a
// tick passes the idle and done states, a pixel also multiply and divide,
// where the restoring divider retires one quotient bit per cycle in all four
// lanes at once. The front accepts items into a two-entry queue while it has
// room, and a finished result waits in the output register without stalling
// the divider's next load. Configuration is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while the block is idle,
// which the block does not enforce; writes past the register list are dropped.
// ----------------------------------------------------------------------------
module stepped_pingpong_crossfade #(
  parameter int MAX_STAGES   = spc_pkg::DEF_MAX_STAGES,
  parameter int CHANNEL_BITS = spc_pkg::DEF_CHANNEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [spc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_data,
  spc_item_if.sink                        item,
  spc_result_if.source                    result
);

  localparam int SW = $clog2(MAX_STAGES);

  // Queue entry: everything the back end needs to finish one item, with the
  // stage data already resolved by the front.
  typedef struct packed {
    logic                                  kind;
    logic [SW-1:0]                         stage;
    logic [SW-1:0]                         k;
    logic [SW-1:0]                         top;
    logic                                  redraw;
    logic [spc_pkg::LANES-1:0][CHANNEL_BITS-1:0] src;
    logic [spc_pkg::LANES-1:0][CHANNEL_BITS-1:0] dst;
  } entry_t;

  spc_pkg::cfg_t cfg;
  entry_t        push_data;
  logic          push_valid;
  logic          push_ready;
  entry_t        pop_data;
  logic          pop_valid;
  logic          pop_ready;

  // Configuration registers: decode the index, drop writes past the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stage_count    <= spc_pkg::RST_STAGE_COUNT;
      cfg.stage_delay_ms <= spc_pkg::RST_STAGE_DELAY_MS;
      cfg.loop_enable    <= spc_pkg::RST_LOOP_ENABLE;
    end else if (cfg_we) begin
      case (cfg_index)
        spc_pkg::CFG_STAGE_COUNT: begin
          cfg.stage_count <= cfg_data[spc_pkg::STAGE_COUNT_W-1:0];
        end
        spc_pkg::CFG_STAGE_DELAY_MS: begin
          cfg.stage_delay_ms <= cfg_data[spc_pkg::MS_W-1:0];
        end
        spc_pkg::CFG_LOOP_ENABLE: begin
          cfg.loop_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: accept beats while the queue has room, advance the tick sequencer, tag the entry.
  spc_front #(
    .MAX_STAGES  (MAX_STAGES),
    .CHANNEL_BITS(CHANNEL_BITS),
    .entry_t     (entry_t)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  // Queue: decouple the front from the multi-cycle blend.
  spc_queue #(
    .entry_t(entry_t)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  // Back: multiply, divide bit by bit, hold the result beat until taken.
  spc_back #(
    .MAX_STAGES  (MAX_STAGES),
    .CHANNEL_BITS(CHANNEL_BITS),
    .entry_t     (entry_t)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .result   (result)
  );

endmodule
